### rtl/dlml_pkg.sv
// Shared types and constants for the discrete Laplace mixture likelihood block.
// No dependencies.
`timescale 1ns / 1ps

package dlml_pkg;

  localparam logic [1:0] REQ_CENTER = 2'd0;
  localparam logic [1:0] REQ_PROB   = 2'd1;
  localparam logic [1:0] REQ_TAU    = 2'd2;
  localparam logic [1:0] REQ_LOCUS  = 2'd3;

  localparam logic [31:0] Q32_MAX = 32'hFFFF_FFFF;
  localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;
  localparam int          EMIT_LIMIT = 16;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FDIV,
    S_RD,
    S_DIFF,
    S_POWA,
    S_POWB,
    S_W1,
    S_W2,
    S_F1,
    S_F2,
    S_WR,
    S_SRD,
    S_SADD,
    S_ERD,
    S_EST,
    S_EDIV,
    S_EOUT,
    S_TOUT
  } dlml_state_e;

endpackage

### rtl/dlml_div.sv
// Bit-serial fractional divider: floor(w * 2^32 / t), saturated when w >= t.
// Uses dlml_pkg.
`timescale 1ns / 1ps

module dlml_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] w_i,
  input  logic [63:0] t_i,
  output logic        done_o,
  output logic [31:0] q_o
);
  import dlml_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [31:0] quo_q, quo_d;
  logic [64:0] shifted;
  logic        take;

  assign shifted = {rem_q, 1'b0};
  assign take    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      den_d = t_i;
      rem_d = w_i;
      quo_d = '0;
      cnt_d = '0;
      if (w_i >= t_i) begin
        quo_d = Q32_MAX;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      // one quotient bit per cycle, restoring
      rem_d = take ? 64'(shifted - {1'b0, den_q}) : shifted[63:0];
      quo_d = {quo_q[30:0], take};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign q_o    = quo_q;

endmodule

### rtl/discrete_laplace_mixture_likelihood.sv
// Top level of the discrete Laplace mixture likelihood block.
// Uses dlml_pkg and dlml_div.
`timescale 1ns / 1ps

// The block holds per-cluster, per-locus center alleles and parameters p in
// synchronous tables, plus a mixing weight tau per cluster. Loading p also
// computes (1-p)/(1+p) with the serial divider; centre and tau loads are
// written as they are accepted. A haplotype locus transfer walks all
// MAX_CLUSTERS clusters in turn, each through read, power by square and
// multiply (on the one shared 32x32 multiplier), the multiply states S_W1,
// S_W2, S_F1 and S_F2 for the 96-bit products and a write back; power steps
// and S_W1/S_W2 are skipped when the distance is zero, and all but the write
// back when the locus index is out of range.
// On the last locus the running weights of the emitted clusters are summed,
// then each emitted cluster result waits for a posterior division (none when
// the total is zero), followed by the total result. Only one transfer is in
// work at a time; input stall is high from acceptance until the work, results
// included, is done. No clearing pass is needed after reset.

module discrete_laplace_mixture_likelihood #(
  parameter int MAX_CLUSTERS    = 16,
  parameter int MAX_LOCI        = 32,
  parameter int ALLELE_BITS     = 8,
  parameter int PARAM_FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  cluster_index_i,
  input  logic [4:0]  locus_index_i,
  input  logic [7:0]  allele_i,
  input  logic [31:0] param_value_i,
  input  logic        last_locus_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_cluster_o,
  output logic [63:0] weight_o,
  output logic [31:0] posterior_o,
  output logic        is_total_o,
  output logic        zero_total_o,
  output logic        last_result_o
);
  import dlml_pkg::*;

  localparam int DEPTH    = MAX_CLUSTERS * MAX_LOCI;
  localparam int TA_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CL_W     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int AB       = ALLELE_BITS;
  localparam int BIT_W    = $clog2(AB);
  localparam int EMIT_MAX = (MAX_CLUSTERS < EMIT_LIMIT) ? MAX_CLUSTERS : EMIT_LIMIT;

  // tables
  logic [AB-1:0] center_mem [DEPTH];
  logic [31:0]   prob_mem   [DEPTH];
  logic [31:0]   factor_mem [DEPTH];
  logic [31:0]   tau_mem    [MAX_CLUSTERS];
  logic [63:0]   acc_mem    [MAX_CLUSTERS];

  dlml_state_e state_q, state_d;

  logic          in_xfer, out_xfer;
  logic          addr_ok;
  logic [TA_W-1:0] ld_addr, q_addr;
  logic [31:0]   p32;

  logic [4:0]    cfg_q;
  logic          active_q;
  logic [CL_W-1:0] c_q, last_idx;
  logic [TA_W-1:0] addr_q;
  logic [31:0]   p_q;
  logic [4:0]    loc_q;
  logic          loc_ok_q;
  logic [AB-1:0] x_q;
  logic          last_q;

  logic [AB-1:0] center_rd_q;
  logic [31:0]   prob_rd_q, factor_rd_q, tau_rd_q;
  logic [63:0]   acc_rd_q;

  logic [AB-1:0] d_q, d_calc;
  logic [31:0]   base_q, r_q, plo_q;
  logic          r_one_q;
  logic [BIT_W-1:0] bit_q;
  logic [63:0]   w_q, total_q;
  logic [31:0]   post_q;
  logic [64:0]   sum;
  logic          c_end, zt;

  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;

  logic          div_start, div_done;
  logic [63:0]   div_w, div_t;
  logic [31:0]   div_q;

  assign in_xfer  = (state_q == S_IDLE) && in_valid_i;
  assign out_xfer = out_valid_o && !out_stall_i;

  assign addr_ok = (32'(cluster_index_i) < MAX_CLUSTERS) && (32'(locus_index_i) < MAX_LOCI);
  assign ld_addr = TA_W'(32'(cluster_index_i) * MAX_LOCI + 32'(locus_index_i));
  assign q_addr  = TA_W'(32'(c_q) * MAX_LOCI + 32'(loc_q));
  // Q0.PARAM_FRAC_BITS widened to Q0.32; high bits fall off the top
  assign p32     = param_value_i << (32 - PARAM_FRAC_BITS);

  assign d_calc = (x_q >= center_rd_q) ? AB'(x_q - center_rd_q) : AB'(center_rd_q - x_q);
  assign c_end  = (c_q == last_idx);
  assign zt     = (total_q == 64'd0);
  assign sum    = {1'b0, total_q} + {1'b0, acc_rd_q};

  // clusters emitted: 0 acts as 1, capped at the table size and at sixteen
  always_comb begin
    if (cfg_q == 5'd0) begin
      last_idx = '0;
    end else if (cfg_q > 5'(EMIT_MAX)) begin
      last_idx = CL_W'(EMIT_MAX - 1);
    end else begin
      last_idx = CL_W'(cfg_q - 5'd1);
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = base_q;
    mul_b = base_q;
    case (state_q)
      S_POWA: begin
        mul_a = r_q;
        mul_b = base_q;
      end
      S_W1: begin
        mul_a = w_q[31:0];
        mul_b = r_q;
      end
      S_W2: begin
        mul_a = w_q[63:32];
        mul_b = r_q;
      end
      S_F1: begin
        mul_a = w_q[31:0];
        mul_b = factor_rd_q;
      end
      S_F2: begin
        mul_a = w_q[63:32];
        mul_b = factor_rd_q;
      end
      default: begin
        mul_a = base_q;
        mul_b = base_q;
      end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  // divider shared by the (1-p)/(1+p) factor and the posteriors
  assign div_start = (in_xfer && (req_type_i == REQ_PROB) && addr_ok) ||
                     ((state_q == S_EST) && !zt);
  assign div_w = (state_q == S_IDLE) ? Q32_ONE - 64'(p32) : acc_rd_q;
  assign div_t = (state_q == S_IDLE) ? Q32_ONE + 64'(p32) : total_q;

  dlml_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .w_i     (div_w),
    .t_i     (div_t),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (req_type_i == REQ_PROB && addr_ok) begin
            state_d = S_FDIV;
          end else if (req_type_i == REQ_LOCUS) begin
            state_d = S_RD;
          end
        end
      end
      S_FDIV: if (div_done) state_d = S_IDLE;
      S_RD:   state_d = S_DIFF;
      S_DIFF: begin
        if (!loc_ok_q) begin
          state_d = S_WR;
        end else if (d_calc != '0) begin
          state_d = S_POWA;
        end else begin
          state_d = S_F1;
        end
      end
      S_POWA: state_d = S_POWB;
      S_POWB: state_d = (bit_q == BIT_W'(AB - 1)) ? S_W1 : S_POWA;
      S_W1:   state_d = S_W2;
      S_W2:   state_d = S_F1;
      S_F1:   state_d = S_F2;
      S_F2:   state_d = S_WR;
      S_WR: begin
        if (c_q == CL_W'(MAX_CLUSTERS - 1)) begin
          state_d = last_q ? S_SRD : S_IDLE;
        end else begin
          state_d = S_RD;
        end
      end
      S_SRD:  state_d = S_SADD;
      S_SADD: state_d = c_end ? S_ERD : S_SRD;
      S_ERD:  state_d = S_EST;
      S_EST:  state_d = zt ? S_EOUT : S_EDIV;
      S_EDIV: if (div_done) state_d = S_EOUT;
      S_EOUT: if (!out_stall_i) state_d = c_end ? S_TOUT : S_ERD;
      S_TOUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // port outputs
  always_comb begin
    in_stall_o    = (state_q != S_IDLE);
    out_valid_o   = (state_q == S_EOUT) || (state_q == S_TOUT);
    is_total_o    = (state_q == S_TOUT);
    last_result_o = (state_q == S_TOUT);
    zero_total_o  = zt;
    out_cluster_o = (state_q == S_TOUT) ? 4'd0 : 4'(c_q);
    weight_o      = (state_q == S_TOUT) ? total_q : acc_rd_q;
    posterior_o   = (state_q == S_TOUT) ? 32'd0 : post_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cfg_q    <= 5'd1;
      active_q <= 1'b0;
      c_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: if (in_xfer) c_q <= '0;
        S_WR: begin
          if (c_q == CL_W'(MAX_CLUSTERS - 1)) begin
            c_q      <= '0;
            active_q <= 1'b1;
          end else begin
            c_q <= c_q + CL_W'(1);
          end
        end
        S_SADD: c_q <= c_end ? '0 : c_q + CL_W'(1);
        S_EOUT: if (out_xfer && !c_end) c_q <= c_q + CL_W'(1);
        S_TOUT: if (out_xfer) active_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        addr_q   <= ld_addr;
        p_q      <= p32;
        loc_q    <= locus_index_i;
        loc_ok_q <= 32'(locus_index_i) < MAX_LOCI;
        x_q      <= AB'(allele_i);
        last_q   <= last_locus_i;
        total_q  <= '0;
      end
      S_DIFF: begin
        w_q     <= active_q ? acc_rd_q : {tau_rd_q, 32'd0};
        d_q     <= d_calc;
        base_q  <= prob_rd_q;
        r_one_q <= 1'b1;
        bit_q   <= '0;
      end
      S_POWA: begin
        if (d_q[bit_q]) begin
          r_q     <= r_one_q ? base_q : prod[63:32];
          r_one_q <= 1'b0;
        end
      end
      S_POWB: begin
        base_q <= prod[63:32];
        bit_q  <= bit_q + BIT_W'(1);
      end
      S_W1: plo_q <= prod[63:32];
      S_W2: w_q   <= prod + 64'(plo_q);
      S_F1: plo_q <= prod[63:32];
      S_F2: w_q   <= prod + 64'(plo_q);
      S_SADD: total_q <= sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
      S_EST:  if (zt) post_q <= '0;
      S_EDIV: if (div_done) post_q <= div_q;
      default: ;
    endcase
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (in_xfer && req_type_i == REQ_CENTER && addr_ok) begin
      center_mem[ld_addr] <= AB'(allele_i);
    end
    if (state_q == S_FDIV && div_done) begin
      prob_mem[addr_q]   <= p_q;
      factor_mem[addr_q] <= div_q;
    end
    if (in_xfer && req_type_i == REQ_TAU && 32'(cluster_index_i) < MAX_CLUSTERS) begin
      tau_mem[CL_W'(cluster_index_i)] <= p32;
    end
    if (state_q == S_WR) begin
      acc_mem[c_q] <= w_q;
    end
  end

  // table reads, registered
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      center_rd_q <= center_mem[q_addr];
      prob_rd_q   <= prob_mem[q_addr];
      factor_rd_q <= factor_mem[q_addr];
      tau_rd_q    <= tau_mem[c_q];
    end
    if (state_q == S_RD || state_q == S_SRD || state_q == S_ERD) begin
      acc_rd_q <= acc_mem[c_q];
    end
  end

endmodule
